[design/wsbc_pkg.sv]
// ----------------------------------------------------------------------------
// wsbc_pkg: shared types for the working-set block cache policy
// Request, response and configuration payloads plus register indexes.
// ----------------------------------------------------------------------------
package wsbc_pkg;

   typedef struct packed {
      logic        kind;
      logic [31:0] block_key;
      logic [31:0] now_time;
      logic [15:0] block_bytes;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] found_bytes;
      logic [6:0]  evicted_count;
      logic        inserted_new;
   } rsp_type;

   localparam logic       KIND_LOOKUP = 1'b0;
   localparam logic       KIND_INSERT = 1'b1;
   localparam logic [0:0] REG_CAPACITY = 1'b0;
   localparam logic [0:0] REG_TAU      = 1'b1;
   localparam logic [6:0] CAP_RESET = 7'd64;
   localparam logic [31:0] TAU_RESET = 32'd1000;

endpackage

[design/working_set_block_cache_policy_top.sv]
// ----------------------------------------------------------------------------
// working_set_block_cache_policy_top
// Fully associative block-id metadata cache, working-set / LFU eviction.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction (lookup or insert); rsp_* returns exactly one
//   response per request. csr_* writes capacity_used (index 0) or window_tau
//   (index 1); write only while the block is idle.
//   Entries live in one memory with a registered read; a sequencer
//   walks it. Every request but a zero-size insert scans MAX_ENTRIES slots for
//   the key; a lookup miss then answers, a hit first updates its entry and
//   an insert with room first fills the lowest free slot.
//   A zero-size insert answers without a scan.
//   An insert that misses in a full cache first recomputes every entry's
//   bucket (serial remainder), then walks up to 2*capacity bucket passes over
//   all MAX_ENTRIES slots, ending early once there is room, and a victim
//   scan if no room was made.
//   One request at a time; req_ready is low while one is in flight.
//   The response sits in an output register until rsp_ready; the block takes
//   the next request in the cycle after the response is taken.
//   Reset (synchronous) clears valid bits, entry count and insert counter;
//   slot payload needs no clearing.
// ----------------------------------------------------------------------------
module working_set_block_cache_policy_top #(
   parameter int MAX_ENTRIES = 64,
   parameter int REF_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  wsbc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output wsbc_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam logic [REF_BITS-1:0] REF_MAX = '1;
   localparam logic [5:0] BK_LAST = 6'd34;   // write-back step of the per-slot bucket recompute

   typedef struct packed {
      logic [31:0]         key;
      logic [15:0]         bytes;
      logic [31:0]         last;
      logic [REF_BITS-1:0] refs;
      logic [31:0]         seq;
      logic [7:0]          bkt;
   } slot_type;

   typedef enum logic [3:0] {
      S_IDLE, S_FIND, S_UPDATE, S_BKT, S_P1, S_P2, S_FREE, S_WRITE, S_RESP
   } state_type;

   slot_type mem [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff;
   slot_type rd_ff;
   logic [IW-1:0] rd_idx_ff;
   logic rd_vld_ff;

   state_type state_ff;
   wsbc_pkg::req_type req_ff;
   wsbc_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;
   logic [6:0] cap_ff;
   logic [31:0] tau_ff;
   logic [CW-1:0] count_ff;
   logic [31:0] inscnt_ff;
   logic [CW-1:0] scan_ff;      // issue index, runs to MAX_ENTRIES
   logic [7:0] bucket_ff;
   logic found_ff;
   logic [IW-1:0] sel_ff;
   slot_type vic_ff;
   logic [7:0] vbk_ff;
   logic [6:0] evict_ff;
   logic [5:0] bk_step_ff;
   logic [31:0] div_key_ff;
   logic [7:0] div_rem_ff;

   // effective capacity and bucket count
   logic [CW-1:0] cap_eff;
   logic [7:0] nbk;
   always_comb begin
      if (cap_ff == '0) cap_eff = CW'(1);
      else if (32'(cap_ff) > 32'(MAX_ENTRIES)) cap_eff = CW'(MAX_ENTRIES);
      else cap_eff = CW'(cap_ff);
      nbk = 8'(cap_eff) << 1;
   end

   // one restoring-remainder step per cycle, key MSB first
   logic [8:0] div_trial;
   logic [7:0] rem_next;
   always_comb begin
      div_trial = {div_rem_ff, div_key_ff[31]};
      if (div_trial >= {1'b0, nbk}) rem_next = 8'(div_trial - {1'b0, nbk});
      else rem_next = div_trial[7:0];
   end

   logic [7:0] rd_bk;
   assign rd_bk = rd_ff.bkt;
   logic [31:0] rd_age;
   assign rd_age = req_ff.now_time - rd_ff.last;
   logic scan_done;
   assign scan_done = (scan_ff == CW'(MAX_ENTRIES));
   logic [IW-1:0] rd_addr;
   assign rd_addr = (state_ff == S_UPDATE) ? sel_ff : scan_ff[IW-1:0];

   // victim comparison
   logic better;
   always_comb begin
      if (!found_ff) better = 1'b1;
      else if (rd_ff.refs != vic_ff.refs) better = rd_ff.refs < vic_ff.refs;
      else if (rd_ff.last != vic_ff.last) better = rd_ff.last < vic_ff.last;
      else if (rd_bk != vbk_ff) better = rd_bk < vbk_ff;
      else better = (inscnt_ff - rd_ff.seq) < (inscnt_ff - vic_ff.seq);
   end

   // lowest free slot
   logic free_any;
   logic [IW-1:0] free_idx;
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   logic we;
   logic [IW-1:0] wa;
   slot_type wd;
   always_comb begin
      we = 1'b0;
      wa = sel_ff;
      wd = rd_ff;
      if (state_ff == S_UPDATE && rd_vld_ff) begin
         we = 1'b1;
         wd.last = req_ff.now_time;
         if (rd_ff.refs != REF_MAX) wd.refs = rd_ff.refs + 1'b1;
         if (req_ff.kind == wsbc_pkg::KIND_INSERT) wd.bytes = req_ff.block_bytes;
      end else if (state_ff == S_WRITE && found_ff) begin
         we = 1'b1;
         wd.key = req_ff.block_key;
         wd.bytes = req_ff.block_bytes;
         wd.last = req_ff.now_time;
         wd.refs = REF_BITS'(1);
         wd.seq = inscnt_ff;
      end else if (state_ff == S_BKT && bk_step_ff == BK_LAST) begin
         we = 1'b1;
         wa = scan_ff[IW-1:0];
         wd.bkt = div_rem_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[rd_addr];
      rd_idx_ff <= rd_addr;
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
         inscnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cap_ff <= wsbc_pkg::CAP_RESET;
         tau_ff <= wsbc_pkg::TAU_RESET;
         rd_vld_ff <= 1'b0;
         scan_ff <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == wsbc_pkg::REG_CAPACITY) cap_ff <= csr_wdata[6:0];
            else tau_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         // read issued this cycle returns next cycle
         rd_vld_ff <= (!scan_done && (state_ff == S_FIND || state_ff == S_P1 ||
                      state_ff == S_P2)) || (state_ff == S_UPDATE && !rd_vld_ff);
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff <= req_data;
                  rsp_ff <= '0;
                  evict_ff <= '0;
                  found_ff <= 1'b0;
                  scan_ff <= '0;
                  if (req_data.kind == wsbc_pkg::KIND_INSERT && req_data.block_bytes == '0)
                     state_ff <= S_RESP;
                  else state_ff <= S_FIND;
               end
            end
            S_FIND: begin
               if (!scan_done) scan_ff <= scan_ff + 1'b1;
               if (rd_vld_ff && !found_ff && valid_ff[rd_idx_ff] &&
                   rd_ff.key == req_ff.block_key) begin
                  found_ff <= 1'b1;
                  sel_ff <= rd_idx_ff;
               end
               if (scan_done && !rd_vld_ff) begin
                  scan_ff <= '0;
                  if (found_ff) begin
                     rsp_ff.hit <= 1'b1;
                     state_ff <= S_UPDATE;
                  end else if (req_ff.kind == wsbc_pkg::KIND_LOOKUP) begin
                     state_ff <= S_RESP;
                  end else if (count_ff >= cap_eff) begin
                     bk_step_ff <= '0;
                     state_ff <= S_BKT;
                  end else begin
                     state_ff <= S_FREE;
                  end
               end
            end
            S_UPDATE: begin
               // rd_ff holds mem[sel_ff] once rd_vld_ff is set
               if (rd_vld_ff) begin
                  if (req_ff.kind == wsbc_pkg::KIND_LOOKUP) rsp_ff.found_bytes <= rd_ff.bytes;
                  state_ff <= S_RESP;
               end
            end
            S_BKT: begin
               // bucket of each valid slot for the current capacity
               if (bk_step_ff == '0) begin
                  if (scan_done) begin
                     scan_ff <= '0;
                     bucket_ff <= '0;
                     state_ff <= S_P1;
                  end else bk_step_ff <= 6'd1;
               end else if (bk_step_ff == 6'd1) begin
                  if (valid_ff[scan_ff[IW-1:0]]) begin
                     div_key_ff <= rd_ff.key;
                     div_rem_ff <= '0;
                     bk_step_ff <= 6'd2;
                  end else begin
                     scan_ff <= scan_ff + 1'b1;
                     bk_step_ff <= '0;
                  end
               end else if (bk_step_ff == BK_LAST) begin
                  scan_ff <= scan_ff + 1'b1;
                  bk_step_ff <= '0;
               end else begin
                  div_key_ff <= div_key_ff << 1;
                  div_rem_ff <= rem_next;
                  bk_step_ff <= bk_step_ff + 1'b1;
               end
            end
            S_P1: begin
               if (!scan_done) scan_ff <= scan_ff + 1'b1;
               if (rd_vld_ff && valid_ff[rd_idx_ff] && rd_bk == bucket_ff &&
                   rd_age > tau_ff) begin
                  valid_ff[rd_idx_ff] <= 1'b0;
                  count_ff <= count_ff - 1'b1;
                  evict_ff <= evict_ff + 1'b1;
               end
               if (scan_done && !rd_vld_ff) begin
                  scan_ff <= '0;
                  if (count_ff < cap_eff) state_ff <= S_FREE;
                  else if (bucket_ff + 1'b1 >= nbk) begin
                     found_ff <= 1'b0;
                     state_ff <= S_P2;
                  end else bucket_ff <= bucket_ff + 1'b1;
               end
            end
            S_P2: begin
               if (!scan_done) scan_ff <= scan_ff + 1'b1;
               if (rd_vld_ff && valid_ff[rd_idx_ff] && better) begin
                  found_ff <= 1'b1;
                  sel_ff <= rd_idx_ff;
                  vic_ff <= rd_ff;
                  vbk_ff <= rd_bk;
               end
               if (scan_done && !rd_vld_ff) begin
                  scan_ff <= '0;
                  if (found_ff) begin
                     valid_ff[sel_ff] <= 1'b0;
                     count_ff <= count_ff - 1'b1;
                     evict_ff <= evict_ff + 1'b1;
                  end
                  state_ff <= S_FREE;
               end
            end
            S_FREE: begin
               found_ff <= free_any;
               sel_ff <= free_idx;
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (found_ff) begin
                  valid_ff[sel_ff] <= 1'b1;
                  count_ff <= count_ff + 1'b1;
                  inscnt_ff <= inscnt_ff + 1'b1;
                  rsp_ff.inserted_new <= 1'b1;
               end
               rsp_ff.evicted_count <= evict_ff;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES)) else $error("entry count overflow");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff) else $error("response dropped");
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff) else $error("request taken while response pending");
   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(count_ff)) else $error("count mismatch");

endmodule
